@@ design/pqenc_pkg.sv @@
// pqenc_pkg: widths, stage map, curve constants and step functions for the
// pq inverse transfer encoder pipeline; no dependencies
package pqenc_pkg;

  localparam int IN_WIDTH      = 20;
  localparam int IN_FRAC_BITS  = 4;
  localparam int OUT_FRAC_BITS = 16;
  localparam int OUT_WIDTH     = OUT_FRAC_BITS + 1;
  localparam int LOG_FB        = 28;
  localparam int MANT_FB       = 30;
  localparam int LOG_W         = LOG_FB + 5;
  localparam int NB_W          = 5;
  localparam int DIV_STEPS     = 30;
  localparam int DV_W          = 35;
  localparam int NUM_W         = 37;
  localparam int E2_W          = 40;
  localparam int IP2_W         = E2_W - LOG_FB;
  localparam int SH_W          = IP2_W + 1;

  // curve constants: m1 = 2610/2^14, m2 = 2523/2^5, c1 = 3424/2^12,
  // c2 = 2413/2^7, c3 = 2392/2^7
  localparam int M1_NUM = 2610;
  localparam int M1_SH  = 14;
  localparam int M2_NUM = 2523;
  localparam int M2_SH  = 5;
  localparam int C1_NUM = 3424;
  localparam int C1_SH  = MANT_FB - 12;
  localparam int C2_NUM = 2413;
  localparam int C3_NUM = 2392;
  localparam int C_SH   = 7;

  localparam longint unsigned DENOM = 64'd10000 << IN_FRAC_BITS;

  // pipeline stage map
  localparam int ST_L1    = 0;
  localparam int ST_NEGL  = ST_L1 + LOG_FB + 1;
  localparam int ST_E1    = ST_NEGL + 1;
  localparam int ST_P     = ST_E1 + LOG_FB + 1;
  localparam int ST_DIV   = ST_P + 1;
  localparam int ST_N2    = ST_DIV + DIV_STEPS + 1;
  localparam int ST_NEGL2 = ST_N2 + LOG_FB + 1;
  localparam int ST_E2    = ST_NEGL2 + 1;
  localparam int ST_RND   = ST_E2 + LOG_FB + 1;
  localparam int N_ST     = ST_RND + 1;

  typedef logic [MANT_FB:0]  mant_t;
  typedef logic [LOG_FB-1:0] frac_t;
  typedef logic [LOG_W-1:0]  lg_t;
  typedef logic [NB_W-1:0]   nb_t;
  typedef logic [DV_W-1:0]   dv_t;

  typedef struct packed {
    logic  b;
    mant_t m;
  } lstep_t;

  function automatic longint unsigned top_bit_f(longint unsigned v);
    longint unsigned n;
    n = 0;
    for (int i = 1; i < 64; i++) begin
      if ((v >> i) != 0) n = longint'(i);
    end
    return n;
  endfunction

  function automatic longint unsigned log2_q28_f(longint unsigned v);
    longint unsigned n;
    longint unsigned m;
    longint unsigned fr;
    n  = top_bit_f(v);
    m  = (n <= MANT_FB) ? (v << (MANT_FB - n)) : (v >> (n - MANT_FB));
    fr = 0;
    for (int k = 1; k <= LOG_FB; k++) begin
      m = (m * m) >> MANT_FB;
      if (m >= (64'd2 << MANT_FB)) begin
        m  = m >> 1;
        fr = fr | (64'd1 << (LOG_FB - k));
      end
    end
    return (n << LOG_FB) + fr;
  endfunction

  function automatic longint unsigned floor_sqrt_f(longint unsigned v);
    longint unsigned x;
    longint unsigned res;
    longint unsigned bt;
    x   = v;
    res = 0;
    bt  = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bt > x) bt = bt >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bt != 0) begin
        if (x >= res + bt) begin
          x   = x - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
    end
    return res;
  endfunction

  // 2^(-2^-k) in q30
  function automatic mant_t exp_root_f(int k);
    longint unsigned s;
    s = 64'd1 << (MANT_FB - 1);
    for (int i = 1; i <= k; i++) begin
      s = floor_sqrt_f(s << MANT_FB);
    end
    return mant_t'(s);
  endfunction

  localparam lg_t DLOG = lg_t'(log2_q28_f(DENOM));

  // one squaring step of the log2 fraction
  function automatic lstep_t log_step_f(mant_t m);
    logic [2*MANT_FB+1:0] sq;
    logic [MANT_FB+1:0]   t;
    lstep_t               res;
    sq = {{(MANT_FB+1){1'b0}}, m} * {{(MANT_FB+1){1'b0}}, m};
    t  = sq[2*MANT_FB+1:MANT_FB];
    if (t[MANT_FB+1]) begin
      res.b = 1'b1;
      res.m = t[MANT_FB+1:1];
    end else begin
      res.b = 1'b0;
      res.m = t[MANT_FB:0];
    end
    return res;
  endfunction

  function automatic mant_t exp_step_f(mant_t r, mant_t s);
    logic [2*MANT_FB+1:0] pr;
    pr = {{(MANT_FB+1){1'b0}}, r} * {{(MANT_FB+1){1'b0}}, s};
    return pr[2*MANT_FB:MANT_FB];
  endfunction

endpackage

@@ design/pq_transfer_encode_core.sv @@
// pq_transfer_encode_core: pipelined smpte st 2084 pq inverse eotf, nits in,
// q1.16 code out; depends on pqenc_pkg

// One item per clock enters and one result per clock leaves while the
// output is not stalled. Most stages hold one squaring step of a log2,
// one root-table multiply of an exp2, or one restoring divide step, so
// the stage count follows from the 28 fraction bits of each log2/exp2 and
// the 30 quotient bits of the ratio. A stall on the output while out_valid
// is high freezes the whole pipeline and stalls the input in the same cycle.
module pq_transfer_encode_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [pqenc_pkg::IN_WIDTH-1:0] in_nits_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [pqenc_pkg::OUT_WIDTH-1:0]      out_pq_code
);
  import pqenc_pkg::*;

  localparam logic [OUT_WIDTH-1:0] FULL = OUT_WIDTH'(1) << OUT_FRAC_BITS;

  logic             en;
  logic [N_ST-1:0]  vld_r;
  logic [N_ST-1:0]  sat_r, sat_nxt;
  logic [N_ST-1:0]  zp_r;

  assign en        = !vld_r[N_ST-1] || !out_stall;
  assign in_stall  = !en;
  assign out_valid = vld_r[N_ST-1];

  // input normalize
  logic [IN_WIDTH-1:0] raw;
  logic                in_neg, in_zp, in_sat;
  nb_t                 in_n;
  logic [63:0]         in_sh;

  always_comb begin
    raw    = in_nits_in;
    in_neg = raw[IN_WIDTH-1];
    in_zp  = in_neg || (raw == '0);
    in_sat = !in_neg && (64'(raw) >= DENOM);
    in_n   = '0;
    for (int i = 1; i < IN_WIDTH - 1; i++) begin
      if (raw[i]) in_n = NB_W'(i);
    end
    in_sh = 64'(raw[IN_WIDTH-2:0]) << (MANT_FB - int'(in_n));
  end

  // division quotient saturation flag feeds the sideband
  logic qs;

  always_comb begin
    sat_nxt         = {sat_r[N_ST-2:0], in_sat};
    sat_nxt[ST_DIV] = sat_r[ST_DIV-1] | qs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N_ST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat_r <= sat_nxt;
      zp_r  <= {zp_r[N_ST-2:0], in_zp};
    end
  end

  // first log2: log2 of the input
  mant_t l1_m_r [LOG_FB+1];
  frac_t l1_f_r [LOG_FB+1];
  nb_t   l1_n_r [LOG_FB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      l1_m_r[0] <= in_sh[MANT_FB:0];
      l1_f_r[0] <= '0;
      l1_n_r[0] <= in_n;
    end
  end

  for (genvar k = 1; k <= LOG_FB; k++) begin : g_l1
    lstep_t st;
    frac_t  f_nxt;
    always_comb begin
      st    = log_step_f(l1_m_r[k-1]);
      f_nxt = l1_f_r[k-1];
      f_nxt[LOG_FB-k] = st.b;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        l1_m_r[k] <= st.m;
        l1_f_r[k] <= f_nxt;
        l1_n_r[k] <= l1_n_r[k-1];
      end
    end
  end

  // -log2(y) and exponent times m1
  lg_t                   negl_r;
  logic [LOG_W+11:0]     e1_prod;

  assign e1_prod = {12'b0, negl_r} * (LOG_W+12)'(M1_NUM);

  always_ff @(posedge clk) begin
    if (en) begin
      negl_r <= DLOG - {l1_n_r[LOG_FB], l1_f_r[LOG_FB]};
    end
  end

  // first exp2: p = 2^-e
  mant_t x1_r_r [LOG_FB+1];
  lg_t   x1_e_r [LOG_FB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r_r[0] <= mant_t'(1) << MANT_FB;
      x1_e_r[0] <= LOG_W'(e1_prod >> M1_SH);
    end
  end

  for (genvar k = 1; k <= LOG_FB; k++) begin : g_x1
    localparam mant_t S_K = exp_root_f(k);
    mant_t r_nxt;
    always_comb begin
      r_nxt = x1_e_r[k-1][LOG_FB-k] ? exp_step_f(x1_r_r[k-1], S_K) : x1_r_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        x1_r_r[k] <= r_nxt;
        x1_e_r[k] <= x1_e_r[k-1];
      end
    end
  end

  mant_t p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= zp_r[ST_P-1] ? '0 :
             (x1_r_r[LOG_FB] >> x1_e_r[LOG_FB][LOG_W-1:LOG_FB]);
    end
  end

  // ratio (c1 + c2 p) / (1 + c3 p), restoring division
  logic [NUM_W-1:0] num, den;
  dv_t              dv_n, dv_d;

  // products need the extra shift bits before scaling down
  always_comb begin
    num  = (NUM_W'(C1_NUM) << C1_SH) +
           NUM_W'(((NUM_W+C_SH)'(C2_NUM) * (NUM_W+C_SH)'(p_r)) >> C_SH);
    den  = (NUM_W'(1) << MANT_FB) +
           NUM_W'(((NUM_W+C_SH)'(C3_NUM) * (NUM_W+C_SH)'(p_r)) >> C_SH);
    dv_n = DV_W'(num >> 2);
    dv_d = DV_W'(den >> 2);
    qs   = dv_n >= dv_d;
  end

  dv_t                  dv_rem_r [DIV_STEPS+1];
  dv_t                  dv_d_r   [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] dv_q_r   [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem_r[0] <= dv_n;
      dv_d_r[0]   <= dv_d;
      dv_q_r[0]   <= '0;
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_dv
    logic [DV_W:0] t;
    logic          ge;
    dv_t           rem_nxt;
    always_comb begin
      t       = {dv_rem_r[k-1], 1'b0};
      ge      = t >= {1'b0, dv_d_r[k-1]};
      rem_nxt = ge ? DV_W'(t - {1'b0, dv_d_r[k-1]}) : DV_W'(t);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[k] <= rem_nxt;
        dv_d_r[k]   <= dv_d_r[k-1];
        dv_q_r[k]   <= {dv_q_r[k-1][DIV_STEPS-2:0], ge};
      end
    end
  end

  // second log2: log2 of the ratio
  logic [DIV_STEPS-1:0] q2;
  nb_t                  n2;
  logic [63:0]          q2_sh;

  always_comb begin
    q2 = dv_q_r[DIV_STEPS];
    n2 = '0;
    for (int i = 1; i < DIV_STEPS; i++) begin
      if (q2[i]) n2 = NB_W'(i);
    end
    q2_sh = 64'(q2) << (MANT_FB - int'(n2));
  end

  mant_t l2_m_r [LOG_FB+1];
  frac_t l2_f_r [LOG_FB+1];
  nb_t   l2_n_r [LOG_FB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      l2_m_r[0] <= q2_sh[MANT_FB:0];
      l2_f_r[0] <= '0;
      l2_n_r[0] <= n2;
    end
  end

  for (genvar k = 1; k <= LOG_FB; k++) begin : g_l2
    lstep_t st;
    frac_t  f_nxt;
    always_comb begin
      st    = log_step_f(l2_m_r[k-1]);
      f_nxt = l2_f_r[k-1];
      f_nxt[LOG_FB-k] = st.b;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        l2_m_r[k] <= st.m;
        l2_f_r[k] <= f_nxt;
        l2_n_r[k] <= l2_n_r[k-1];
      end
    end
  end

  lg_t               negl2_r;
  logic [LOG_W+11:0] e2_prod;

  assign e2_prod = {12'b0, negl2_r} * (LOG_W+12)'(M2_NUM);

  always_ff @(posedge clk) begin
    if (en) begin
      negl2_r <= (LOG_W'(MANT_FB) << LOG_FB) - {l2_n_r[LOG_FB], l2_f_r[LOG_FB]};
    end
  end

  // second exp2: ratio^m2
  mant_t            x2_r_r [LOG_FB+1];
  logic [E2_W-1:0]  x2_e_r [LOG_FB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      x2_r_r[0] <= mant_t'(1) << MANT_FB;
      x2_e_r[0] <= E2_W'(e2_prod >> M2_SH);
    end
  end

  for (genvar k = 1; k <= LOG_FB; k++) begin : g_x2
    localparam mant_t S_K = exp_root_f(k);
    mant_t r_nxt;
    always_comb begin
      r_nxt = x2_e_r[k-1][LOG_FB-k] ? exp_step_f(x2_r_r[k-1], S_K) : x2_r_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        x2_r_r[k] <= r_nxt;
        x2_e_r[k] <= x2_e_r[k-1];
      end
    end
  end

  // integer part shift with round half up, clamp to one
  logic [SH_W-1:0]      sh;
  logic [63:0]          sum, shv;
  logic [OUT_WIDTH-1:0] res_nxt;
  logic [OUT_WIDTH-1:0] res_r;

  always_comb begin
    sh  = {1'b0, x2_e_r[LOG_FB][E2_W-1:LOG_FB]} + SH_W'(MANT_FB - OUT_FRAC_BITS);
    sum = 64'(x2_r_r[LOG_FB]) + (64'd1 << (sh - SH_W'(1)));
    shv = sum >> sh;
    if (sat_r[ST_RND-1]) begin
      res_nxt = FULL;
    end else if (sh >= SH_W'(62)) begin
      res_nxt = '0;
    end else if (shv > 64'(FULL)) begin
      res_nxt = FULL;
    end else begin
      res_nxt = shv[OUT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_pq_code = res_r;

endmodule

@@ dv/tb_pq_transfer_encode_core.sv @@
// tb_pq_transfer_encode_core: random and directed test of the pq inverse eotf pipeline
// predicts each code with a local fixed-point model; depends on pqenc_pkg and the core

class pq_code_board;
  int unsigned expected_q[$];
  int unsigned mismatches;
  int unsigned orphans;

  function new();
    mismatches = 0;
    orphans = 0;
  endfunction

  // position of the highest set bit
  static function int unsigned msb_pos(longint unsigned v);
    int unsigned n;
    n = 0;
    for (int i = 1; i < 64; i++) begin
      if ((v >> i) != 0) n = i;
    end
    return n;
  endfunction

  // log2 magnitude with 28 fraction bits, by repeated squaring
  static function longint unsigned lg2_q28(longint unsigned v);
    int unsigned n;
    longint unsigned m;
    longint unsigned fr;
    n = msb_pos(v);
    m = (n <= 30) ? (v << (30 - n)) : (v >> (n - 30));
    fr = 0;
    for (int k = 1; k <= 28; k++) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        fr = fr | (64'd1 << (28 - k));
      end
    end
    return (longint'(n) << 28) + fr;
  endfunction

  static function longint unsigned isqrt(longint unsigned v);
    longint unsigned x;
    longint unsigned res;
    longint unsigned bt;
    x = v;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt = bt >> 2;
    while (bt != 0) begin
      if (x >= res + bt) begin
        x = x - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // 2^-f in q30 for a q28 fraction
  static function longint unsigned pow2_neg(longint unsigned f);
    longint unsigned r;
    longint unsigned s;
    r = 64'd1 << 30;
    s = 64'd1 << 29;
    for (int k = 1; k <= 28; k++) begin
      s = isqrt(s << 30);
      if ((f >> (28 - k)) & 1) r = (r * s) >> 30;
    end
    return r;
  endfunction

  static function int unsigned pq_encode(logic [19:0] nits);
    longint unsigned raw;
    longint unsigned lim;
    longint unsigned p;
    longint unsigned num;
    longint unsigned den;
    longint unsigned q;
    longint unsigned e;
    longint unsigned ip;
    longint unsigned r;
    longint unsigned sh;
    longint unsigned res;
    raw = 64'(nits);
    lim = 64'd10000 << 4;
    p = 0;
    if (!nits[19] && raw >= lim) return 1 << 16;
    if (!nits[19] && raw != 0) begin
      e = ((lg2_q28(lim) - lg2_q28(raw)) * 2610) >> 14;
      ip = e >> 28;
      r = pow2_neg(e & ((64'd1 << 28) - 1));
      p = (ip >= 31) ? 0 : (r >> ip);
    end
    num = (64'd3424 << 18) + ((64'd2413 * p) >> 7);
    den = (64'd1 << 30) + ((64'd2392 * p) >> 7);
    q = ((num >> 2) << 30) / (den >> 2);
    if (q >= (64'd1 << 30)) return 1 << 16;
    e = (((64'd30 << 28) - lg2_q28(q)) * 2523) >> 5;
    ip = e >> 28;
    r = pow2_neg(e & ((64'd1 << 28) - 1));
    sh = ip + 14;
    if (sh >= 62) res = 0;
    else res = (r + (64'd1 << (sh - 1))) >> sh;
    if (res > (1 << 16)) res = 1 << 16;
    return int'(res);
  endfunction

  function void note_item(logic [19:0] nits);
    expected_q.push_back(pq_encode(nits));
  endfunction

  function void check_code(int unsigned code);
    int unsigned exp_code;
    if (expected_q.size() == 0) begin
      orphans++;
      if (mismatches + orphans <= 10) $display("unexpected code %0d", code);
      return;
    end
    exp_code = expected_q.pop_front();
    if (exp_code != code) begin
      mismatches++;
      if (mismatches + orphans <= 10) $display("code mismatch: expected %0d got %0d", exp_code, code);
    end
  endfunction
endclass

module tb_pq_transfer_encode_core;
  import pqenc_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [IN_WIDTH-1:0] in_nits_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [OUT_WIDTH-1:0] out_pq_code;

  pq_code_board board = new();
  int unsigned cyc = 0;
  bit hold_request = 1'b0;

  always #2 clk = ~clk;

  pq_transfer_encode_core u_top (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_nits_in(in_nits_in), .out_valid(out_valid), .out_stall(out_stall),
    .out_pq_code(out_pq_code)
  );

  always @(posedge clk) cyc <= cyc + 1;

  // result side: random stalls, quiet stretch, one long hold-off
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_code(32'(out_pq_code));
  end

  initial begin
    int unsigned n;
    @(posedge clk);
    while (1) begin
      if (hold_request) begin
        out_stall <= 1'b1;
        for (n = 0; n < 400; n++) @(posedge clk);
        hold_request = 1'b0;
      end
      if (cyc > 3000 && cyc < 4500) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(99) < 37);
      @(posedge clk);
    end
  end

  task automatic send_item(logic [19:0] nits, bit may_idle);
    if (may_idle) begin
      while ($urandom_range(99) < 37) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_nits_in <= nits;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_item(nits);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [19:0] rand_nits();
    int unsigned sel;
    sel = $urandom_range(9);
    case (sel)
      0: return 20'($urandom_range(15));
      1: return 20'($urandom_range(2000));
      2: return 20'($urandom_range(160000));
      3: return 20'(160000 + $urandom_range(4000)) - 20'd2000;
      4: return 20'(1 << $urandom_range(19)) + 20'($urandom_range(3)) - 20'd1;
      default: return 20'($urandom);
    endcase
  endfunction

  initial begin
    logic [19:0] directed_vals[$];
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_vals = '{20'd0, 20'd1, 20'd2, 20'd16, 20'd159999, 20'd160000, 20'd160001,
                      20'h7ffff, 20'h80000, 20'hfffff, 20'd100, 20'd1600, 20'd16000,
                      20'd3, 20'd80000, 20'h55555, 20'haaaaa, 20'd7};
    foreach (directed_vals[i]) send_item(directed_vals[i], 1'b0);
    for (int i = 0; i < 1830; i++) begin
      if (i == 300) hold_request = 1'b1;
      if (i == 900) drain();
      send_item(rand_nits(), !(cyc > 3000 && cyc < 4500));
    end
    drain();
    repeat (200) @(posedge clk);
    if (board.mismatches == 0 && board.orphans == 0)
      $display("tb_pq_transfer_encode_core: done, clean");
    else
      $display("tb_pq_transfer_encode_core: done, errors");
    $finish;
  end

  initial begin
    #400000;
    $display("tb_pq_transfer_encode_core: done, errors");
    $finish;
  end
endmodule

@@ sim.f @@
design/pqenc_pkg.sv
design/pq_transfer_encode_core.sv
dv/tb_pq_transfer_encode_core.sv
